// ===== hdl/smpq_pkg.sv =====
`timescale 1ns / 1ps
package smpq_pkg;

    localparam int DATA_W = 32;
    localparam int OCC_W  = 7;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PCMP = 5'b00010,
        S_PWR  = 5'b00100,
        S_POP  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // latch request, seed the hole at the tail
        logic is_push;    // op of the accepted request
        logic rd_head;    // read the front entry instead of the one below the hole
        logic shift;      // move the entry below the hole up into it
        logic write_val;  // drop the pushed value into the hole
        logic pop_take;   // return the front entry and advance the front
        logic load_out;   // move the result into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
        logic gt;         // entry below the hole is greater than the pushed value
        logic last;       // hole sits one above the front
    } t_sts;

endpackage

// ===== hdl/smpq_ctrl.sv =====
`timescale 1ns / 1ps
module smpq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_op,
    input  logic            i_out_ready,
    input  smpq_pkg::t_sts  i_sts,
    output smpq_pkg::t_cmd  o_cmd,
    output logic            o_in_ready,
    output logic            o_out_valid
);

    smpq_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             accept;
    logic             out_free;

    assign accept   = (r_state == smpq_pkg::S_IDLE) && i_in_valid;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.is_push   = (i_op == smpq_pkg::OP_PUSH);
        o_cmd.rd_head   = (i_op == smpq_pkg::OP_POP);
        case (r_state)
            smpq_pkg::S_IDLE: begin
                if (accept) begin
                    o_cmd.accept = 1'b1;
                    if (i_op == smpq_pkg::OP_POP) begin
                        n_state = i_sts.empty ? smpq_pkg::S_OUT : smpq_pkg::S_POP;
                    end else if (i_sts.full) begin
                        n_state = smpq_pkg::S_OUT;
                    end else if (i_sts.empty) begin
                        n_state = smpq_pkg::S_PWR;
                    end else begin
                        n_state = smpq_pkg::S_PCMP;
                    end
                end
            end
            smpq_pkg::S_PCMP: begin
                o_cmd.rd_head = 1'b0;
                if (i_sts.gt) begin
                    o_cmd.shift = 1'b1;
                    if (i_sts.last) begin
                        n_state = smpq_pkg::S_PWR;
                    end
                end else begin
                    o_cmd.write_val = 1'b1;
                    n_state         = smpq_pkg::S_OUT;
                end
            end
            smpq_pkg::S_PWR: begin
                o_cmd.rd_head   = 1'b0;
                o_cmd.write_val = 1'b1;
                n_state         = smpq_pkg::S_OUT;
            end
            smpq_pkg::S_POP: begin
                o_cmd.pop_take = 1'b1;
                n_state        = smpq_pkg::S_OUT;
            end
            smpq_pkg::S_OUT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = smpq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = smpq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smpq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == smpq_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/smpq_datapath.sv =====
`timescale 1ns / 1ps
module smpq_datapath #(
    parameter int DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  smpq_pkg::t_cmd                     i_cmd,
    input  logic signed [smpq_pkg::DATA_W-1:0] i_push_value,
    output smpq_pkg::t_sts                     o_sts,
    output logic signed [smpq_pkg::DATA_W-1:0] o_popped_value,
    output logic                               o_popped_valid,
    output logic                               o_push_dropped,
    output logic        [smpq_pkg::OCC_W-1:0]  o_occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == LAST_ADDR) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        ptr_dec = (p == '0) ? LAST_ADDR : p - 1'b1;
    endfunction

    logic signed [smpq_pkg::DATA_W-1:0] mem [DEPTH];
    logic signed [smpq_pkg::DATA_W-1:0] r_rd_data;

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_hole;
    logic [CW-1:0] r_idx;
    logic signed [smpq_pkg::DATA_W-1:0] r_val;

    logic signed [smpq_pkg::DATA_W-1:0] r_res_value;
    logic                               r_res_valid;
    logic                               r_res_dropped;

    logic [AW-1:0]                      rd_addr;
    logic                               we;
    logic signed [smpq_pkg::DATA_W-1:0] wd;

    // Walk the hole down: next read sits two below the current hole.
    always_comb begin
        if (i_cmd.accept && i_cmd.rd_head) begin
            rd_addr = r_head;
        end else if (i_cmd.accept) begin
            rd_addr = ptr_dec(r_tail);
        end else begin
            rd_addr = ptr_dec(ptr_dec(r_hole));
        end
    end

    assign we = i_cmd.shift || i_cmd.write_val;
    assign wd = i_cmd.shift ? r_rd_data : r_val;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_hole] <= wd;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_cmd.write_val) begin
            n_tail  = ptr_inc(r_tail);
            n_count = r_count + 1'b1;
        end else if (i_cmd.pop_take) begin
            n_head  = ptr_inc(r_head);
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_val         <= i_push_value;
            r_hole        <= r_tail;
            r_idx         <= r_count;
            r_res_value   <= '0;
            r_res_valid   <= 1'b0;
            r_res_dropped <= i_cmd.is_push && o_sts.full;
        end else if (i_cmd.shift) begin
            r_hole <= ptr_dec(r_hole);
            r_idx  <= r_idx - 1'b1;
        end else if (i_cmd.pop_take) begin
            r_res_value <= r_rd_data;
            r_res_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_popped_value <= r_res_value;
            o_popped_valid <= r_res_valid;
            o_push_dropped <= r_res_dropped;
            o_occupancy    <= smpq_pkg::OCC_W'(r_count);
        end
    end

    assign o_sts.full  = (r_count == CW'(DEPTH));
    assign o_sts.empty = (r_count == '0);
    assign o_sts.gt    = (r_rd_data > r_val);
    assign o_sts.last  = (r_idx == CW'(1));

endmodule

// ===== hdl/sorted_min_priority_queue.sv =====
`timescale 1ns / 1ps
// Flow: a pop passes S_POP and S_OUT to the output register; an empty pop or a refused push
//   goes straight to S_OUT; a push walks past each stored value greater than the new one.
// Requests: one at a time; the next is taken once the previous result enters the output
//   register, and S_OUT waits while the output register still holds an unaccepted result.
// Reset: synchronous active-low i_rst_n empties the queue; entry storage is not cleared.
module sorted_min_priority_queue #(
    parameter int DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_op,
    input  logic signed [smpq_pkg::DATA_W-1:0] i_push_value,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [smpq_pkg::DATA_W-1:0] o_popped_value,
    output logic                               o_popped_valid,
    output logic                               o_push_dropped,
    output logic        [smpq_pkg::OCC_W-1:0]  o_occupancy
);

    // The entries live in a circular buffer in one memory: the front moves on a
    // pop, so a pop costs no shifting. A push opens a hole at the tail and walks
    // it down toward the front, moving each larger entry up by one, one entry per
    // cycle. Equal values stay below the new one, so equal values leave in
    // arrival order.
    smpq_pkg::t_cmd cmd;
    smpq_pkg::t_sts sts;

    smpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    smpq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_push_value   (i_push_value),
        .o_sts          (sts),
        .o_popped_value (o_popped_value),
        .o_popped_valid (o_popped_valid),
        .o_push_dropped (o_push_dropped),
        .o_occupancy    (o_occupancy)
    );

endmodule

// ===== hdl/smpq_checker.sv =====
`timescale 1ns / 1ps
module smpq_checker #(
    parameter int DEPTH = 64
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic signed [smpq_pkg::DATA_W-1:0] o_popped_value,
    input logic                               o_popped_valid,
    input logic                               o_push_dropped,
    input logic        [smpq_pkg::OCC_W-1:0]  o_occupancy
);

    // A result held back stays unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_popped_value)
            && $stable(o_occupancy))
        else $error("result changed while stalled");

    // A request is never taken in two consecutive cycles.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken back to back");

    // A pop result and a drop flag never come together.
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_popped_valid && o_push_dropped))
        else $error("popped and dropped both set");

    // Without a valid pop the value reads zero.
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_popped_valid |-> o_popped_value == '0)
        else $error("nonzero value without a pop");

    // A drop only happens on a full queue.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_push_dropped |-> o_occupancy == smpq_pkg::OCC_W'(DEPTH))
        else $error("push dropped below full");

endmodule

bind sorted_min_priority_queue smpq_checker #(
    .DEPTH (DEPTH)
) u_smpq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_popped_value (o_popped_value),
    .o_popped_valid (o_popped_valid),
    .o_push_dropped (o_push_dropped),
    .o_occupancy    (o_occupancy)
);

// ===== bench/sorted_min_priority_queue_tb.sv =====
`timescale 1ns / 1ps
module sorted_min_priority_queue_tb;

    localparam int DEPTH = 64;

    // One result as seen on the output port
    typedef struct {
        logic signed [smpq_pkg::DATA_W-1:0] popped_value;
        logic                               popped_valid;
        logic                               push_dropped;
        logic        [smpq_pkg::OCC_W-1:0]  occupancy;
    } t_pq_result;

    // Track the sorted contents and the results still owed by the block
    class t_min_queue_tracker;
        logic signed [smpq_pkg::DATA_W-1:0] held_values[$];
        t_pq_result                         owed_results[$];
        int                                 capacity;
        int                                 mismatches;

        function new(int depth);
            capacity   = depth;
            mismatches = 0;
        endfunction

        task report_mismatch(string what, longint got, longint want);
            mismatches++;
            $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        endtask

        // Apply one accepted request and queue the result it must produce
        task note_request(logic op, logic signed [smpq_pkg::DATA_W-1:0] value);
            t_pq_result r;
            int         slot;
            r.popped_value = '0;
            r.popped_valid = 1'b0;
            r.push_dropped = 1'b0;
            if (op == smpq_pkg::OP_PUSH) begin
                if (held_values.size() >= capacity) begin
                    r.push_dropped = 1'b1;
                end else begin
                    // walk down past every stored value greater than the new one
                    slot = held_values.size();
                    while (slot > 0 && held_values[slot-1] > value) slot--;
                    held_values.insert(slot, value);
                end
            end else if (held_values.size() > 0) begin
                r.popped_value = held_values.pop_front();
                r.popped_valid = 1'b1;
            end
            r.occupancy = smpq_pkg::OCC_W'(held_values.size());
            owed_results.push_back(r);
        endtask

        task check_result(t_pq_result got);
            t_pq_result want;
            if (owed_results.size() == 0) begin
                report_mismatch("result with no request outstanding", 0, 0);
            end else begin
                want = owed_results.pop_front();
                if (got.popped_value !== want.popped_value)
                    report_mismatch("popped_value", got.popped_value, want.popped_value);
                if (got.popped_valid !== want.popped_valid)
                    report_mismatch("popped_valid", got.popped_valid, want.popped_valid);
                if (got.push_dropped !== want.push_dropped)
                    report_mismatch("push_dropped", got.push_dropped, want.push_dropped);
                if (got.occupancy !== want.occupancy)
                    report_mismatch("occupancy", got.occupancy, want.occupancy);
            end
        endtask
    endclass

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_ready;
    logic                               i_op = smpq_pkg::OP_PUSH;
    logic signed [smpq_pkg::DATA_W-1:0] i_push_value = '0;
    logic                               o_out_valid;
    logic                               i_out_ready = 1'b0;
    logic signed [smpq_pkg::DATA_W-1:0] o_popped_value;
    logic                               o_popped_valid;
    logic                               o_push_dropped;
    logic        [smpq_pkg::OCC_W-1:0]  o_occupancy;

    t_min_queue_tracker tracker;
    int                 send_idle_pct = 29;
    int                 recv_idle_pct = 81;

    sorted_min_priority_queue #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_push_value  (i_push_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_popped_value(o_popped_value),
        .o_popped_valid(o_popped_valid),
        .o_push_dropped(o_push_dropped),
        .o_occupancy   (o_occupancy)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stall the result channel at random
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Sample at the falling edge: a handshake seen here completes at the next rising edge
    always @(negedge i_clk) begin
        t_pq_result got;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready) begin
            got.popped_value = o_popped_value;
            got.popped_valid = o_popped_valid;
            got.push_dropped = o_push_dropped;
            got.occupancy    = o_occupancy;
            tracker.check_result(got);
        end
    end

    // Present one request, hold it until taken, then record it
    task automatic send_request(input logic op,
                                input logic signed [smpq_pkg::DATA_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_push_value <= value;
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        tracker.note_request(op, value);
    endtask

    // Hold off new requests until every owed result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.owed_results.size() != 0);
    endtask

    // Mix wide random words with narrow ranges so ties and extremes are frequent
    function automatic logic signed [smpq_pkg::DATA_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(9);
        case (sel)
            0, 1, 2, 3: begin
                return $urandom;
            end
            4, 5, 6: begin
                return $signed($urandom_range(8)) - 4;
            end
            7: begin
                case ($urandom_range(3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: begin
                return $signed($urandom_range(200)) - 100;
            end
        endcase
    endfunction

    initial begin
        int push_bias[4];
        int push_pct;
        tracker = new(DEPTH);
        push_bias = '{92, 55, 8, 45};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: pop on empty, extremes, ties, then drain past empty
        send_request(smpq_pkg::OP_POP, 32'sh7FFF_FFFF);
        send_request(smpq_pkg::OP_PUSH, 32'sd0);
        send_request(smpq_pkg::OP_PUSH, 32'sh7FFF_FFFF);
        send_request(smpq_pkg::OP_PUSH, 32'sh8000_0000);
        send_request(smpq_pkg::OP_PUSH, -32'sd1);
        send_request(smpq_pkg::OP_PUSH, 32'sd1);
        send_request(smpq_pkg::OP_PUSH, 32'sd5);
        send_request(smpq_pkg::OP_PUSH, 32'sd5);
        send_request(smpq_pkg::OP_PUSH, -32'sd1);
        send_request(smpq_pkg::OP_PUSH, 32'sh8000_0000);
        repeat (10) send_request(smpq_pkg::OP_POP, $urandom);
        send_request(smpq_pkg::OP_POP, 32'sh8000_0000);
        drain_results();

        // Random: chunks rotate the push bias (92, 55, 8, 45 percent) and the idle rates
        for (int chunk = 0; chunk < 8; chunk++) begin
            if (chunk < 3) begin
                send_idle_pct = 29;
                recv_idle_pct = 81;
            end else if (chunk < 6) begin
                send_idle_pct = 81;
                recv_idle_pct = 29;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            push_pct = push_bias[chunk % 4];
            for (int n = 0; n < 80; n++) begin
                send_request(($urandom_range(99) < push_pct) ? smpq_pkg::OP_PUSH
                                                              : smpq_pkg::OP_POP,
                             pick_value());
            end
            drain_results();
        end

        // Let any stray result show up before the verdict
        repeat (100) @(posedge i_clk);
        if (tracker.mismatches == 0) begin
            $display("sorted_min_priority_queue test passed");
        end else begin
            $display("sorted_min_priority_queue test failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("sorted_min_priority_queue test failed");
        $finish;
    end

endmodule
